>>> rtl/asac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asac_pkg
// Shared types and constants for the axis smoothing and calibration block.
// ----------------------------------------------------------------------------
package asac_pkg;

    localparam int SAMPLE_W       = 12;
    localparam int CNT_W          = 4;
    localparam int SIMQ_W         = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 12;

    localparam int DEF_NUM_PINS       = 64;
    localparam int DEF_NUM_AXES       = 8;
    localparam int DEF_SETTLE_SAMPLES = 8;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;
    localparam logic [SAMPLE_W-1:0] MIN_SPAN   = 12'd256;
    // 65535 / 4095 = 16 + 15/4095, and 4095 / 15 = 273
    localparam logic [SAMPLE_W-1:0] SIM_DIV    = 12'd273;
    localparam logic [CNT_W-1:0]    CNT_MAX    = 4'd15;

    localparam logic [SAMPLE_W-1:0] RST_LOW_BAND  = 12'd64;
    localparam logic [SAMPLE_W-1:0] RST_HIGH_BAND = 12'd64;
    localparam logic [SAMPLE_W-1:0] RST_DEADBAND  = 12'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_BAND    = 3'd0,
        CFG_HIGH_BAND   = 3'd1,
        CFG_DEADBAND    = 3'd2,
        CFG_INVERT_MASK = 3'd3,
        CFG_SIM_MODE    = 3'd4,
        CFG_HID_IN_SIM  = 3'd5,
        CFG_PANEL_FORCE = 3'd6
    } cfg_idx_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOOK  = 7'b0000010,
        ST_SCALE = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_SNAP  = 7'b0010000,
        ST_SIMQ  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

>>> rtl/asac_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asac_div
// Bit-serial restoring divider: one quotient bit per cycle. The quotient
// must fit in SAMPLE_W bits (upper dividend half below the divisor).
// ----------------------------------------------------------------------------
module asac_div
    import asac_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic [2*SAMPLE_W-1:0]   dividend,
    input  wire logic [SAMPLE_W-1:0]     divisor,
    output logic      [SAMPLE_W-1:0]     quotient,
    output div_stat_t                    stat
);

    localparam int STEP_W = $clog2(SAMPLE_W + 1);

    logic [SAMPLE_W-1:0] rem_reg;
    logic [SAMPLE_W-1:0] lo_reg;
    logic [SAMPLE_W-1:0] q_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [SAMPLE_W:0]   trial;
    logic                ge;

    assign trial = {rem_reg, lo_reg[SAMPLE_W-1]};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(SAMPLE_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[2*SAMPLE_W-1:SAMPLE_W];
            lo_reg  <= dividend[SAMPLE_W-1:0];
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? SAMPLE_W'(trial - {1'b0, divisor}) : trial[SAMPLE_W-1:0];
            lo_reg  <= {lo_reg[SAMPLE_W-2:0], 1'b0};
            q_reg   <= {q_reg[SAMPLE_W-2:0], ge};
        end
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

>>> rtl/axis_smoothing_autocalibration.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// axis_smoothing_autocalibration
// Per-pin smoothing, per-axis min/max calibration, settle and deadband.
// ----------------------------------------------------------------------------
// One beat is worked on at a time. A recalibrate or out-of-range beat is
// taken without leaving idle; a sample that sends nothing goes through the
// lookup state back to idle. A sending sample goes on to scale and then, on
// an uncalibrated axis, straight to the 4-step conversion to the 16-bit
// simulator value; at either end of a learned span it passes snap first, and
// inside the span the bit-serial divide and snap. A finished result waits in
// the output register while the next beat is taken; a sending beat holds in
// its done state while an earlier result is still waiting there. The per-pin
// filter, last-sent and settle-count stores are single-port memories read
// on acceptance; seeded, settled and count-valid flags are flip-flops.
// ----------------------------------------------------------------------------
module axis_smoothing_autocalibration
    import asac_pkg::*;
#(
    parameter int NUM_PINS       = DEF_NUM_PINS,
    parameter int NUM_AXES       = DEF_NUM_AXES,
    parameter int SETTLE_SAMPLES = DEF_SETTLE_SAMPLES
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_operation,
    input  wire logic [5:0]            s_pin,
    input  wire logic [2:0]            s_axis,
    input  wire logic [SAMPLE_W-1:0]   s_raw_sample,
    input  wire logic                  s_force_req,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [2:0]                 m_axis_out,
    output logic                       m_hid_send,
    output logic [SAMPLE_W-1:0]        m_hid_value,
    output logic                       m_hid_force,
    output logic                       m_sim_send,
    output logic [15:0]                m_sim_value,
    output logic                       m_sim_force
);

    localparam int PIN_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
    localparam int AX_W  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    // configuration
    logic [SAMPLE_W-1:0] low_band_reg, high_band_reg, deadband_reg;
    logic [7:0]          inv_mask_reg;
    logic                sim_mode_reg, hid_in_sim_reg, panel_force_reg;

    // control
    state_t              state_reg, state_next;
    logic [NUM_PINS-1:0] seeded_reg, settled_reg, cnt_vld_reg;
    logic [SAMPLE_W-1:0] cal_low_reg  [NUM_AXES];
    logic [SAMPLE_W-1:0] cal_high_reg [NUM_AXES];
    logic                m_valid_reg;

    // per-pin memories
    logic [SAMPLE_W-1:0] smooth_mem [NUM_PINS];
    logic [SAMPLE_W-1:0] last_mem   [NUM_PINS];
    logic [CNT_W-1:0]    cnt_mem    [NUM_PINS];
    logic [SAMPLE_W-1:0] smooth_rd_reg, last_rd_reg;
    logic [CNT_W-1:0]    cnt_rd_reg;

    // beat in flight
    logic [PIN_W-1:0]    pin_reg;
    logic [AX_W-1:0]     ax_reg;
    logic [2:0]          axis_reg;
    logic [SAMPLE_W-1:0] raw_reg;
    logic                force_reg;
    logic [SAMPLE_W-1:0] filt_reg, hid_reg;
    logic                hs_reg, hf_reg, ss_reg, sf_reg;
    logic [SAMPLE_W-1:0] sq_rem_reg;
    logic [SIMQ_W-1:0]   sq_q_reg;
    logic [1:0]          sq_step_reg;

    // output payload
    logic [2:0]          m_axis_reg;
    logic                m_hs_reg, m_hf_reg, m_ss_reg, m_sf_reg;
    logic [SAMPLE_W-1:0] m_hid_reg;
    logic [15:0]         m_sim_reg;

    logic                accept, in_range, out_free;
    logic [PIN_W-1:0]    pin_in;

    assign s_ready  = state_reg == ST_IDLE;
    assign accept   = s_valid && s_ready;
    assign pin_in   = PIN_W'(s_pin);
    assign in_range = (32'(s_pin) < 32'(NUM_PINS)) && (32'(s_axis) < 32'(NUM_AXES));
    assign out_free = !m_valid_reg || m_ready;

    // ---------------- lookup: filter, calibration learn, send decision
    logic                seeded_c, settled_c;
    logic [CNT_W-1:0]    cnt_c, cnt_inc;
    logic [13:0]         sum_c;
    logic [SAMPLE_W-1:0] filt0_c, filt_c, low_c, high_c, diff_c;
    logic                emit_c, upd_last_c, set_settled_c, wr_cnt_c;
    logic [CNT_W-1:0]    cnt_wr_c;
    logic                hs_c, hf_c, ss_c, sf_c;

    always_comb begin
        seeded_c  = seeded_reg[pin_reg];
        settled_c = seeded_c && settled_reg[pin_reg];
        cnt_c     = (seeded_c && cnt_vld_reg[pin_reg]) ? cnt_rd_reg : '0;
        sum_c     = (14'(smooth_rd_reg) << 1) + 14'(smooth_rd_reg) + 14'(raw_reg);
        filt0_c   = seeded_c ? sum_c[13:2] : raw_reg;
        filt_c    = inv_mask_reg[axis_reg] ? FULL_SCALE - filt0_c : filt0_c;
        low_c     = (filt_c < cal_low_reg[ax_reg])  ? filt_c : cal_low_reg[ax_reg];
        high_c    = (filt_c > cal_high_reg[ax_reg]) ? filt_c : cal_high_reg[ax_reg];
        cnt_inc   = (cnt_c < CNT_MAX) ? cnt_c + 1'b1 : cnt_c;
        diff_c    = (filt_c > last_rd_reg) ? filt_c - last_rd_reg : last_rd_reg - filt_c;

        emit_c        = 1'b0;
        upd_last_c    = 1'b0;
        set_settled_c = 1'b0;
        wr_cnt_c      = 1'b0;
        cnt_wr_c      = cnt_inc;
        hs_c = 1'b0; hf_c = 1'b0; ss_c = 1'b0; sf_c = 1'b0;

        if (force_reg) begin
            emit_c        = 1'b1;
            upd_last_c    = 1'b1;
            set_settled_c = 1'b1;
            wr_cnt_c      = 1'b1;
            cnt_wr_c      = CNT_W'(SETTLE_SAMPLES);
            if (sim_mode_reg) begin
                ss_c = 1'b1; sf_c = 1'b1;
                hs_c = hid_in_sim_reg; hf_c = hid_in_sim_reg;
            end else begin
                hs_c = 1'b1; hf_c = 1'b1;
            end
        end else if (!settled_c) begin
            wr_cnt_c = 1'b1;
            if (cnt_inc >= CNT_W'(SETTLE_SAMPLES)) begin
                emit_c        = 1'b1;
                upd_last_c    = 1'b1;
                set_settled_c = 1'b1;
                if (sim_mode_reg) begin
                    ss_c = 1'b1; sf_c = panel_force_reg;
                    hs_c = hid_in_sim_reg;
                end else begin
                    hs_c = 1'b1;
                end
            end
        end else if (diff_c > deadband_reg) begin
            emit_c     = 1'b1;
            upd_last_c = 1'b1;
            if (sim_mode_reg) begin
                ss_c = 1'b1; sf_c = 1'b1;
                hs_c = hid_in_sim_reg;
            end else begin
                hs_c = 1'b1;
            end
        end
    end

    // ---------------- scaling
    logic [SAMPLE_W-1:0]   lo_s, hi_s, dv_s;
    logic                  cal_ok, at_low, at_high, div_start;
    logic [2*SAMPLE_W-1:0] num_s;
    logic [SAMPLE_W-1:0]   quot;
    div_stat_t             div_stat;

    always_comb begin
        lo_s      = cal_low_reg[ax_reg];
        hi_s      = cal_high_reg[ax_reg];
        cal_ok    = (hi_s >= lo_s) && ((hi_s - lo_s) >= MIN_SPAN);
        at_low    = filt_reg <= lo_s;
        at_high   = filt_reg >= hi_s;
        dv_s      = filt_reg - lo_s;
        num_s     = {dv_s, {SAMPLE_W{1'b0}}} - (2*SAMPLE_W)'(dv_s);
        div_start = (state_reg == ST_SCALE) && cal_ok && !at_low && !at_high;
    end

    asac_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_s),
        .divisor  (hi_s - lo_s),
        .quotient (quot),
        .stat     (div_stat)
    );

    logic [SAMPLE_W-1:0] snap_lo, snap_c;

    always_comb begin
        snap_lo = ((hid_reg != '0) && (hid_reg <= low_band_reg)) ? '0 : hid_reg;
        snap_c  = ((snap_lo < FULL_SCALE) && (snap_lo >= FULL_SCALE - high_band_reg))
                  ? FULL_SCALE : snap_lo;
    end

    logic [SAMPLE_W-1:0] sq_trial;
    logic                sq_ge;

    assign sq_trial = SIM_DIV << sq_step_reg;
    assign sq_ge    = sq_rem_reg >= sq_trial;

    // ---------------- sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept && !s_operation && in_range) state_next = ST_LOOK;
            ST_LOOK:  state_next = emit_c ? ST_SCALE : ST_IDLE;
            ST_SCALE: begin
                if (!cal_ok)                state_next = ST_SIMQ;
                else if (at_low || at_high) state_next = ST_SNAP;
                else                        state_next = ST_DIV;
            end
            ST_DIV:   if (div_stat.done) state_next = ST_SNAP;
            ST_SNAP:  state_next = ST_SIMQ;
            ST_SIMQ:  if (sq_step_reg == 2'd0) state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            seeded_reg      <= '0;
            settled_reg     <= '0;
            cnt_vld_reg     <= '0;
            m_valid_reg     <= 1'b0;
            low_band_reg    <= RST_LOW_BAND;
            high_band_reg   <= RST_HIGH_BAND;
            deadband_reg    <= RST_DEADBAND;
            inv_mask_reg    <= '0;
            sim_mode_reg    <= 1'b0;
            hid_in_sim_reg  <= 1'b0;
            panel_force_reg <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                cal_low_reg[i]  <= FULL_SCALE;
                cal_high_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_LOW_BAND:    low_band_reg    <= cfg_wdata;
                    CFG_HIGH_BAND:   high_band_reg   <= cfg_wdata;
                    CFG_DEADBAND:    deadband_reg    <= cfg_wdata;
                    CFG_INVERT_MASK: inv_mask_reg    <= cfg_wdata[7:0];
                    CFG_SIM_MODE:    sim_mode_reg    <= cfg_wdata[0];
                    CFG_HID_IN_SIM:  hid_in_sim_reg  <= cfg_wdata[0];
                    CFG_PANEL_FORCE: panel_force_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end

            if (accept && s_operation) begin
                settled_reg <= '0;
                cnt_vld_reg <= '0;
                for (int i = 0; i < NUM_AXES; i++) begin
                    cal_low_reg[i]  <= FULL_SCALE;
                    cal_high_reg[i] <= '0;
                end
            end else if (state_reg == ST_LOOK) begin
                seeded_reg[pin_reg]   <= 1'b1;
                cal_low_reg[ax_reg]   <= low_c;
                cal_high_reg[ax_reg]  <= high_c;
                settled_reg[pin_reg]  <= settled_c || set_settled_c;
                if (wr_cnt_c) begin
                    cnt_vld_reg[pin_reg] <= 1'b1;
                end
            end

            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // memories
    always_ff @(posedge aclk) begin
        if (accept) begin
            smooth_rd_reg <= smooth_mem[pin_in];
            last_rd_reg   <= last_mem[pin_in];
            cnt_rd_reg    <= cnt_mem[pin_in];
        end
        if (state_reg == ST_LOOK) begin
            smooth_mem[pin_reg] <= filt0_c;
            if (upd_last_c) begin
                last_mem[pin_reg] <= filt_c;
            end
            if (wr_cnt_c) begin
                cnt_mem[pin_reg] <= cnt_wr_c;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            pin_reg   <= pin_in;
            ax_reg    <= AX_W'(s_axis);
            axis_reg  <= s_axis;
            raw_reg   <= s_raw_sample;
            force_reg <= s_force_req;
        end
        unique case (state_reg)
            ST_LOOK: begin
                filt_reg <= filt_c;
                hs_reg   <= hs_c;
                hf_reg   <= hf_c;
                ss_reg   <= ss_c;
                sf_reg   <= sf_c;
            end
            ST_SCALE: begin
                if (!cal_ok) begin
                    hid_reg     <= filt_reg;
                    sq_rem_reg  <= filt_reg;
                    sq_q_reg    <= '0;
                    sq_step_reg <= 2'd3;
                end else if (at_low) begin
                    hid_reg <= '0;
                end else if (at_high) begin
                    hid_reg <= FULL_SCALE;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    hid_reg <= quot;
                end
            end
            ST_SNAP: begin
                hid_reg     <= snap_c;
                sq_rem_reg  <= snap_c;
                sq_q_reg    <= '0;
                sq_step_reg <= 2'd3;
            end
            ST_SIMQ: begin
                if (sq_ge) begin
                    sq_rem_reg <= sq_rem_reg - sq_trial;
                end
                sq_q_reg    <= {sq_q_reg[SIMQ_W-2:0], sq_ge};
                sq_step_reg <= sq_step_reg - 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_axis_reg <= axis_reg;
                    m_hs_reg   <= hs_reg;
                    m_hf_reg   <= hf_reg;
                    m_ss_reg   <= ss_reg;
                    m_sf_reg   <= sf_reg;
                    m_hid_reg  <= hid_reg;
                    m_sim_reg  <= {hid_reg, sq_q_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_axis_out  = m_axis_reg;
    assign m_hid_send  = m_hs_reg;
    assign m_hid_value = m_hid_reg;
    assign m_hid_force = m_hf_reg;
    assign m_sim_send  = m_ss_reg;
    assign m_sim_value = m_sim_reg;
    assign m_sim_force = m_sf_reg;

    // ---------------- checks
    a_div_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised without a finished item");

    a_force_needs_send: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_hs_reg || !m_hf_reg) && (m_ss_reg || !m_sf_reg))
        else $error("force flag set without its send flag");

    a_value_in_span: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCALE |-> (lo_s <= filt_reg) && (filt_reg <= hi_s))
        else $error("filtered value outside learned calibration range");

endmodule
`default_nettype wire
